/* rtl/udp_port_packet_steering_top_defines.svh */
// Assertion macros shared by the steering block.
`ifndef UDP_PORT_PACKET_STEERING_TOP_DEFINES_SVH
`define UDP_PORT_PACKET_STEERING_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define UPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define UPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ups_pkg.sv */
// Types, constants and codes shared by the steering block.
`timescale 1ns / 1ps
package ups_pkg;

   // Sizing
   localparam int NUM_QUEUES      = 64;
   localparam int MAX_FRAME_BYTES = 16384;
   localparam int QADDR_W         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int QUEUE_W    = 6;
   localparam int VERDICT_W  = 2;
   localparam int COUNT_W    = 32;
   localparam int PORT_W     = 16;
   localparam int MASK_W     = 64;
   localparam int POS_W      = 16;
   localparam int KIND_W     = 16;
   localparam int HDR_END_W  = 7;
   localparam int STATUS_W   = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEER_PORT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOCKET_MASK = 2'd1;
   localparam logic [PORT_W-1:0]      STEER_PORT_RESET = 16'd8890;

   // Job queue between parser and counter stage
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Header layout
   localparam int ETH_HDR_LEN  = 14;
   localparam int IPV4_MIN_LEN = 20;
   localparam int IPV6_HDR_LEN = 40;
   localparam int UDP_HDR_LEN  = 8;
   localparam int POS_KIND_HI  = 12;
   localparam int POS_KIND_LO  = 13;
   localparam int POS_IPV4_IHL = 14;
   localparam int POS_IPV4_PROTO = 23;
   localparam int POS_IPV6_NEXT  = 20;
   localparam logic [KIND_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [KIND_W-1:0] ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [BYTE_W-1:0] PROTO_UDP      = 8'd17;

   // Parse status codes
   localparam logic [STATUS_W-1:0] STATUS_OTHER = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IPV4  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IPV6  = 2'd2;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_ABORT    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PASS     = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REDIRECT = 2'd2;

   // Classification handed from the parser to the counter stage
   typedef enum logic [1:0] {
      JOB_ABORT,
      JOB_PASS,
      JOB_MATCH
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [QUEUE_W-1:0]   queue;
   } steer_job_type;

endpackage

/* rtl/ups_req_if.sv */
// Frame byte channel: one frame byte with its queue and end mark per beat.
`timescale 1ns / 1ps
interface ups_req_if;
   import ups_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    frame_byte;
   logic                 end_of_frame;
   logic [QUEUE_W-1:0]   rx_queue;

   modport source (output valid, output frame_byte, output end_of_frame,
                   output rx_queue, input ready);
   modport sink   (input valid, input frame_byte, input end_of_frame,
                   input rx_queue, output ready);
endinterface

/* rtl/ups_rsp_if.sv */
// Verdict channel: one verdict per frame per beat.
`timescale 1ns / 1ps
interface ups_rsp_if;
   import ups_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VERDICT_W-1:0]  verdict;
   logic [QUEUE_W-1:0]    target_queue;
   logic [COUNT_W-1:0]    queue_match_count;

   modport source (output valid, output verdict, output target_queue,
                   output queue_match_count, input ready);
   modport sink   (input valid, input verdict, input target_queue,
                   input queue_match_count, output ready);
endinterface

/* rtl/ups_ram.sv */
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module ups_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read the old contents on a clash
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ups_front.sv */
// Header parser: walks frame bytes and classifies each frame at its end.
`timescale 1ns / 1ps
module ups_front (
   input  logic                    clock,
   input  logic                    reset,
   ups_req_if.sink                 req_chan,
   input  logic [ups_pkg::PORT_W-1:0] steer_port,
   output logic                    push_valid,
   output ups_pkg::steer_job_type  push_job,
   input  logic                    push_ready
);
   import ups_pkg::*;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [HDR_END_W-1:0] hdr_end_ff, hdr_end_in;
   logic [BYTE_W-1:0]    proto_ff, proto_in;
   logic [PORT_W-1:0]    udp_len_ff, udp_len_in;
   logic [PORT_W-1:0]    dport_ff, dport_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 accept;
   logic                 in_window;
   logic [POS_W-1:0]     hdr_pos;
   logic [POS_W-1:0]     frame_len;
   logic [POS_W-1:0]     hdr_len;
   job_kind_type         kind_sel;
   logic [BYTE_W-1:0]    b;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.frame_byte;
   assign in_window      = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign hdr_pos        = POS_W'(hdr_end_ff);

   // Capture header fields at their byte offsets
   always_comb begin
      pos_in     = pos_ff;
      kind_in    = kind_ff;
      hdr_end_in = hdr_end_ff;
      proto_in   = proto_ff;
      udp_len_in = udp_len_ff;
      dport_in   = dport_ff;
      status_in  = status_ff;
      if (in_window) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == POS_W'(POS_KIND_HI)) begin
            kind_in = {b, 8'h00};
         end else if (pos_ff == POS_W'(POS_KIND_LO)) begin
            kind_in = {kind_ff[KIND_W-1:BYTE_W], b};
            if ({kind_ff[KIND_W-1:BYTE_W], b} == ETHERTYPE_IPV4) begin
               status_in = STATUS_IPV4;
            end else if ({kind_ff[KIND_W-1:BYTE_W], b} == ETHERTYPE_IPV6) begin
               status_in  = STATUS_IPV6;
               hdr_end_in = HDR_END_W'(ETH_HDR_LEN + IPV6_HDR_LEN);
            end
         end else if (pos_ff == POS_W'(POS_IPV4_IHL) && status_ff == STATUS_IPV4) begin
            hdr_end_in = HDR_END_W'(ETH_HDR_LEN) + HDR_END_W'({b[3:0], 2'b00});
         end else if (pos_ff == POS_W'(POS_IPV4_PROTO) && status_ff == STATUS_IPV4) begin
            proto_in = b;
         end else if (pos_ff == POS_W'(POS_IPV6_NEXT) && status_ff == STATUS_IPV6) begin
            proto_in = b;
         end
         // UDP fields sit at fixed offsets past the IP header
         if (hdr_end_ff != '0 && pos_ff >= POS_W'(ETH_HDR_LEN)) begin
            if (pos_ff == hdr_pos + POS_W'(2)) begin
               dport_in = {b, 8'h00};
            end else if (pos_ff == hdr_pos + POS_W'(3)) begin
               dport_in = {dport_ff[PORT_W-1:BYTE_W], b};
            end else if (pos_ff == hdr_pos + POS_W'(4)) begin
               udp_len_in = {b, 8'h00};
            end else if (pos_ff == hdr_pos + POS_W'(5)) begin
               udp_len_in = {udp_len_ff[PORT_W-1:BYTE_W], b};
            end
         end
      end
   end

   assign frame_len = pos_in;
   assign hdr_len   = POS_W'(hdr_end_in);

   // Judge the frame from the fields including its final byte
   always_comb begin
      kind_sel = JOB_PASS;
      if (frame_len < POS_W'(ETH_HDR_LEN)) begin
         kind_sel = JOB_ABORT;
      end else if (status_in == STATUS_IPV4 &&
                   (frame_len < POS_W'(ETH_HDR_LEN + IPV4_MIN_LEN) ||
                    hdr_len < POS_W'(ETH_HDR_LEN + IPV4_MIN_LEN) ||
                    hdr_len > frame_len)) begin
         kind_sel = JOB_PASS;
      end else if (status_in == STATUS_IPV6 && frame_len < hdr_len) begin
         kind_sel = JOB_PASS;
      end else if (status_in != STATUS_IPV4 && status_in != STATUS_IPV6) begin
         kind_sel = JOB_PASS;
      end else if (proto_in != PROTO_UDP) begin
         kind_sel = JOB_PASS;
      end else if (hdr_len + POS_W'(UDP_HDR_LEN) > frame_len) begin
         kind_sel = JOB_ABORT;
      end else if (udp_len_in < PORT_W'(UDP_HDR_LEN)) begin
         kind_sel = JOB_ABORT;
      end else if (dport_in != steer_port) begin
         kind_sel = JOB_PASS;
      end else begin
         kind_sel = JOB_MATCH;
      end
   end

   // Hand the verdict job over on the final beat
   assign push_valid     = accept && req_chan.end_of_frame;
   assign push_job.kind  = kind_sel;
   assign push_job.queue = req_chan.rx_queue;

   // Advance the parse state, clear it at the end of each frame
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         kind_ff    <= '0;
         hdr_end_ff <= '0;
         proto_ff   <= '0;
         udp_len_ff <= '0;
         dport_ff   <= '0;
         status_ff  <= STATUS_OTHER;
      end else if (accept) begin
         if (req_chan.end_of_frame) begin
            pos_ff     <= '0;
            kind_ff    <= '0;
            hdr_end_ff <= '0;
            proto_ff   <= '0;
            udp_len_ff <= '0;
            dport_ff   <= '0;
            status_ff  <= STATUS_OTHER;
         end else begin
            pos_ff     <= pos_in;
            kind_ff    <= kind_in;
            hdr_end_ff <= hdr_end_in;
            proto_ff   <= proto_in;
            udp_len_ff <= udp_len_in;
            dport_ff   <= dport_in;
            status_ff  <= status_in;
         end
      end
   end
endmodule

/* rtl/ups_fifo.sv */
// Short job queue between the parser and the counter stage.
`timescale 1ns / 1ps
module ups_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  ups_pkg::steer_job_type push_job,
   output logic                   push_ready,
   output logic                   pop_valid,
   output ups_pkg::steer_job_type pop_job,
   input  logic                   pop_ready
);
   import ups_pkg::*;

   steer_job_type         slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Step pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job in its slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

/* rtl/ups_back.sv */
// Counter stage: bumps per-queue match counters and issues verdicts.
`timescale 1ns / 1ps
`include "udp_port_packet_steering_top_defines.svh"
module ups_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   input  ups_pkg::steer_job_type     pop_job,
   output logic                       pop_ready,
   input  logic [ups_pkg::MASK_W-1:0] socket_mask,
   ups_rsp_if.source                  rsp_chan
);
   import ups_pkg::*;

   // Stage holding the job whose counter is being read
   logic                  b_valid_ff, b_valid_in;
   steer_job_type         b_job_ff;
   logic [QADDR_W-1:0]    b_addr;
   logic                  b_in_range;

   // Last counter write, covering a read issued on the same edge
   logic                  fwd_valid_ff;
   logic [QADDR_W-1:0]    fwd_addr_ff;
   logic [COUNT_W-1:0]    fwd_count_ff;

   logic [NUM_QUEUES-1:0] entry_valid_ff;

   logic                  out_valid_ff;
   logic [VERDICT_W-1:0]  out_verdict_ff, verdict_sel;
   logic [QUEUE_W-1:0]    out_target_ff, target_sel;
   logic [COUNT_W-1:0]    out_count_ff, count_sel;

   logic                  adv;
   logic                  do_pop;
   logic                  ram_we;
   logic [COUNT_W-1:0]    ram_rdata;
   logic [COUNT_W-1:0]    base_count;
   logic [COUNT_W-1:0]    new_count;

   assign adv        = b_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready  = !b_valid_ff || adv;
   assign do_pop     = pop_valid && pop_ready;
   assign b_addr     = b_job_ff.queue[QADDR_W-1:0];
   assign b_in_range = {1'b0, b_job_ff.queue} < (QUEUE_W + 1)'(NUM_QUEUES);
   assign ram_we     = adv && b_job_ff.kind == JOB_MATCH && b_in_range;

   ups_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_QUEUES)
   ) u_counter_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (b_addr),
      .wr_data (new_count),
      .rd_en   (do_pop),
      .rd_addr (pop_job.queue[QADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Pick the current count: last write, stored value, or zero if never written
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == b_addr) begin
         base_count = fwd_count_ff;
      end else if (entry_valid_ff[b_addr]) begin
         base_count = ram_rdata;
      end else begin
         base_count = '0;
      end
   end

   assign new_count = base_count + COUNT_W'(1);

   // Form the verdict beat
   always_comb begin
      verdict_sel = VERDICT_PASS;
      target_sel  = '0;
      count_sel   = b_in_range ? base_count : '0;
      case (b_job_ff.kind)
         JOB_ABORT: begin
            verdict_sel = VERDICT_ABORT;
         end
         JOB_MATCH: begin
            if (b_in_range) begin
               count_sel = new_count;
               if (socket_mask[b_job_ff.queue]) begin
                  verdict_sel = VERDICT_REDIRECT;
                  target_sel  = b_job_ff.queue;
               end
            end
         end
         default: begin
            verdict_sel = VERDICT_PASS;
         end
      endcase
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (do_pop) begin
         b_valid_in = 1'b1;
      end else if (adv) begin
         b_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            fwd_valid_ff           <= 1'b1;
            entry_valid_ff[b_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (do_pop) begin
         b_job_ff <= pop_job;
      end
      if (ram_we) begin
         fwd_addr_ff  <= b_addr;
         fwd_count_ff <= new_count;
      end
      if (adv) begin
         out_verdict_ff <= verdict_sel;
         out_target_ff  <= target_sel;
         out_count_ff   <= count_sel;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.verdict           = out_verdict_ff;
   assign rsp_chan.target_queue      = out_target_ff;
   assign rsp_chan.queue_match_count = out_count_ff;

   `UPS_ASSERT_SAME(redirect_needs_socket, clock, reset,
      rsp_chan.valid && rsp_chan.verdict == VERDICT_REDIRECT,
      socket_mask[rsp_chan.target_queue], "redirect to a queue without a bound socket")
   `UPS_ASSERT_SAME(target_zero_unless_redirect, clock, reset,
      rsp_chan.valid && rsp_chan.verdict != VERDICT_REDIRECT,
      rsp_chan.target_queue == '0, "target queue set on a non-redirect verdict")
   `UPS_ASSERT_NEXT(count_matches_last_write, clock, reset,
      ram_we, rsp_chan.valid && rsp_chan.queue_match_count == fwd_count_ff,
      "reported count differs from the counter just written")
endmodule

/* rtl/udp_port_packet_steering_top.sv */
// Path: a verdict beat passes the job FIFO, counter-read stage and output register.
// Throughput: one frame byte per cycle while the job FIFO has room; the counter stage
//   retires one verdict per cycle while the verdict channel is ready, set by its
//   one counter RAM read and one write per cycle.
// Reset: synchronous, active high; counters read as zero through per-queue valid bits,
//   so no clearing pass is needed before the block takes bytes.
`timescale 1ns / 1ps
module udp_port_packet_steering_top (
   input  logic                            clock,
   input  logic                            reset,
   ups_req_if.sink                         req_chan,
   ups_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [ups_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ups_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import ups_pkg::*;

   logic [PORT_W-1:0] steer_port_ff;
   logic [MASK_W-1:0] socket_mask_ff;

   logic              push_valid;
   steer_job_type     push_job;
   logic              push_ready;
   logic              pop_valid;
   steer_job_type     pop_job;
   logic              pop_ready;

   // Configuration registers; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         steer_port_ff  <= STEER_PORT_RESET;
         socket_mask_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEER_PORT:  steer_port_ff  <= csr_wr_data[PORT_W-1:0];
            CSR_SOCKET_MASK: socket_mask_ff <= csr_wr_data[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ups_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .steer_port (steer_port_ff),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   ups_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   ups_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop_ready   (pop_ready),
      .socket_mask (socket_mask_ff),
      .rsp_chan    (rsp_chan)
   );
endmodule

/* verif/udp_port_packet_steering_top_tb.sv */
// Self-checking bench for the UDP port steering block: frames in, verdicts checked.
`timescale 1ns / 1ps
module udp_port_packet_steering_top_tb;
   import ups_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS   = 10;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [QUEUE_W-1:0]   target;
      logic [COUNT_W-1:0]   count;
   } verdict_rec_type;

   typedef struct packed {
      bit              fixed;
      verdict_rec_type want;
   } verdict_pin_type;

   typedef struct packed {
      bit                  reconfig;
      logic [KIND_W-1:0]   kind;
      logic [3:0]          ihl;
      logic [BYTE_W-1:0]   proto;
      logic [PORT_W-1:0]   dport;
      logic [15:0]         ulen;
      logic [15:0]         len;
      logic [QUEUE_W-1:0]  queue;
      logic [MASK_W-1:0]   mask;
      bit                  fixed;
      verdict_rec_type     want;
   } frame_spec_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   ups_req_if req_link ();
   ups_rsp_if rsp_link ();

   udp_port_packet_steering_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_link),
      .rsp_chan    (rsp_link),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: registers, per-frame parse state, queue counters
   logic [PORT_W-1:0]   port_cfg;
   logic [MASK_W-1:0]   mask_cfg;
   int unsigned         cur_pos;
   logic [KIND_W-1:0]   kind_seen;
   int unsigned         hdr_end;
   logic [BYTE_W-1:0]   l4_proto;
   logic [15:0]         udp_len;
   logic [PORT_W-1:0]   udp_dport;
   logic [STATUS_W-1:0] ip_kind;
   logic [COUNT_W-1:0]  match_count [NUM_QUEUES];

   verdict_rec_type verdicts_due[$];
   verdict_pin_type verdict_pins[$];
   logic [BYTE_W-1:0] frame_bytes[$];
   int  mismatches = 0;
   bit  sender_gappy = 1'b1;
   bit  receiver_gappy = 1'b1;
   bit  hold_request = 1'b0;

   // Parse one accepted beat; on the final byte judge the frame and queue its verdict
   task automatic take_frame_byte(input logic [BYTE_W-1:0] b, input logic last,
                                  input logic [QUEUE_W-1:0] q);
      verdict_rec_type rec;
      verdict_pin_type pin;
      if (cur_pos < MAX_FRAME_BYTES) begin
         if (cur_pos == POS_KIND_HI) begin
            kind_seen = {b, 8'h00};
         end else if (cur_pos == POS_KIND_LO) begin
            kind_seen = {kind_seen[15:8], b};
            if (kind_seen == ETHERTYPE_IPV4) begin
               ip_kind = STATUS_IPV4;
            end else if (kind_seen == ETHERTYPE_IPV6) begin
               ip_kind = STATUS_IPV6;
               hdr_end = ETH_HDR_LEN + IPV6_HDR_LEN;
            end
         end else if (cur_pos == POS_IPV4_IHL && ip_kind == STATUS_IPV4) begin
            hdr_end = ETH_HDR_LEN + 4 * b[3:0];
         end else if (cur_pos == POS_IPV4_PROTO && ip_kind == STATUS_IPV4) begin
            l4_proto = b;
         end else if (cur_pos == POS_IPV6_NEXT && ip_kind == STATUS_IPV6) begin
            l4_proto = b;
         end
         if (hdr_end != 0 && cur_pos >= ETH_HDR_LEN) begin
            if (cur_pos == hdr_end + 2) udp_dport = {b, 8'h00};
            else if (cur_pos == hdr_end + 3) udp_dport = {udp_dport[15:8], b};
            else if (cur_pos == hdr_end + 4) udp_len = {b, 8'h00};
            else if (cur_pos == hdr_end + 5) udp_len = {udp_len[15:8], b};
         end
         cur_pos++;
      end
      if (last) begin
         rec.verdict = VERDICT_PASS;
         rec.target  = '0;
         if (cur_pos < ETH_HDR_LEN) begin
            rec.verdict = VERDICT_ABORT;
         end else if (ip_kind == STATUS_IPV4 && (cur_pos < ETH_HDR_LEN + IPV4_MIN_LEN ||
                      hdr_end < ETH_HDR_LEN + IPV4_MIN_LEN || hdr_end > cur_pos)) begin
            rec.verdict = VERDICT_PASS;
         end else if (ip_kind == STATUS_IPV6 && cur_pos < hdr_end) begin
            rec.verdict = VERDICT_PASS;
         end else if (ip_kind != STATUS_IPV4 && ip_kind != STATUS_IPV6) begin
            rec.verdict = VERDICT_PASS;
         end else if (l4_proto != PROTO_UDP) begin
            rec.verdict = VERDICT_PASS;
         end else if (hdr_end + UDP_HDR_LEN > cur_pos || udp_len < UDP_HDR_LEN) begin
            rec.verdict = VERDICT_ABORT;
         end else if (udp_dport == port_cfg) begin
            match_count[q] = match_count[q] + 1;
            if (mask_cfg[q]) begin
               rec.verdict = VERDICT_REDIRECT;
               rec.target  = q;
            end
         end
         rec.count = match_count[q];
         // a directed row may pin its verdict; the shadow state still advances
         if (verdict_pins.size() != 0) begin
            pin = verdict_pins.pop_front();
            if (pin.fixed) rec = pin.want;
         end
         verdicts_due.push_back(rec);
         cur_pos   = 0;
         kind_seen = '0;
         hdr_end   = 0;
         l4_proto  = '0;
         udp_len   = '0;
         udp_dport = '0;
         ip_kind   = STATUS_OTHER;
      end
   endtask

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      verdict_rec_type want;
      if (!reset) begin
         if (req_link.valid && req_link.ready)
            take_frame_byte(req_link.frame_byte, req_link.end_of_frame, req_link.rx_queue);
         if (rsp_link.valid && rsp_link.ready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: verdict beat with none expected: v=%0d q=%0d n=%0d",
                           $realtime, rsp_link.verdict, rsp_link.target_queue,
                           rsp_link.queue_match_count);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_link.verdict !== want.verdict || rsp_link.target_queue !== want.target
                   || rsp_link.queue_match_count !== want.count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: verdict mismatch: expected v=%0d q=%0d n=%0d, got v=%0d q=%0d n=%0d",
                              $realtime, want.verdict, want.target, want.count,
                              rsp_link.verdict, rsp_link.target_queue,
                              rsp_link.queue_match_count);
               end
            end
         end
      end
   end

   // Receiver: random back-pressure, or a long hold-off on request
   initial begin : receiver
      int held;
      rsp_link.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_link.ready = 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            hold_request = 1'b0;
         end
         rsp_link.ready = receiver_gappy ? ($urandom_range(99) >= 30) : 1'b1;
      end
   end

   function automatic void put_byte(input int unsigned at, input logic [BYTE_W-1:0] value);
      if (at < frame_bytes.size()) frame_bytes[at] = value;
   endfunction

   // Random payload with the header fields of the spec laid over it
   task automatic build_frame(input frame_spec_type spec);
      int unsigned hdr;
      int unsigned i;
      logic [3:0]  version;
      frame_bytes.delete();
      for (i = 0; i < spec.len; i++) frame_bytes.push_back($urandom_range(255));
      put_byte(POS_KIND_HI, spec.kind[15:8]);
      put_byte(POS_KIND_LO, spec.kind[7:0]);
      hdr = 0;
      if (spec.kind == ETHERTYPE_IPV4) begin
         version = $urandom_range(15);
         put_byte(POS_IPV4_IHL, {version, spec.ihl});
         put_byte(POS_IPV4_PROTO, spec.proto);
         hdr = ETH_HDR_LEN + 4 * spec.ihl;
      end else if (spec.kind == ETHERTYPE_IPV6) begin
         put_byte(POS_IPV6_NEXT, spec.proto);
         hdr = ETH_HDR_LEN + IPV6_HDR_LEN;
      end
      if (hdr != 0) begin
         put_byte(hdr + 2, spec.dport[15:8]);
         put_byte(hdr + 3, spec.dport[7:0]);
         put_byte(hdr + 4, spec.ulen[15:8]);
         put_byte(hdr + 5, spec.ulen[7:0]);
      end
   endtask

   // Drive the built frame beat by beat; the queue only counts on the final byte
   task automatic send_frame(input frame_spec_type spec);
      int unsigned     i;
      verdict_pin_type pin;
      pin.fixed = spec.fixed;
      pin.want  = spec.want;
      verdict_pins.push_back(pin);
      for (i = 0; i < frame_bytes.size(); i++) begin
         @(negedge clock);
         while (sender_gappy && $urandom_range(99) < 30) begin
            req_link.valid = 1'b0;
            @(negedge clock);
         end
         req_link.valid        = 1'b1;
         req_link.frame_byte   = frame_bytes[i];
         req_link.end_of_frame = (i == frame_bytes.size() - 1);
         req_link.rx_queue     = req_link.end_of_frame ? spec.queue : $urandom_range(63);
         do @(posedge clock); while (!req_link.ready);
      end
   endtask

   // Drop valid and wait until every verdict has come back
   task automatic drain;
      @(negedge clock);
      req_link.valid = 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_STEER_PORT:  port_cfg = data[PORT_W-1:0];
         CSR_SOCKET_MASK: mask_cfg = data;
         default: ;
      endcase
   endtask

   // Reconfigure only once the block is idle
   task automatic apply_config(input logic [PORT_W-1:0] port, input logic [MASK_W-1:0] mask);
      logic [CSR_DATA_W-1:0] junk;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      junk = {$urandom(), $urandom()};
      write_csr(CSR_STEER_PORT, {junk[CSR_DATA_W-1:PORT_W], port});
      write_csr(CSR_SOCKET_MASK, mask);
      write_csr(CSR_SPARE_LO, {$urandom(), $urandom()});
      write_csr(CSR_SPARE_HI, {$urandom(), $urandom()});
   endtask

   function automatic frame_spec_type frame_row(
      input logic [KIND_W-1:0] kind, input logic [3:0] ihl, input logic [BYTE_W-1:0] proto,
      input logic [PORT_W-1:0] dport, input logic [15:0] ulen, input logic [15:0] len,
      input logic [QUEUE_W-1:0] queue, input bit fixed, input logic [VERDICT_W-1:0] verdict,
      input logic [QUEUE_W-1:0] target, input logic [COUNT_W-1:0] count);
      frame_spec_type spec;
      spec = '0;
      spec.kind  = kind;
      spec.ihl   = ihl;
      spec.proto = proto;
      spec.dport = dport;
      spec.ulen  = ulen;
      spec.len   = len;
      spec.queue = queue;
      spec.fixed = fixed;
      spec.want  = '{verdict: verdict, target: target, count: count};
      return spec;
   endfunction

   function automatic frame_spec_type reconfig_row(input logic [PORT_W-1:0] port,
                                                   input logic [MASK_W-1:0] mask);
      frame_spec_type spec;
      spec = '0;
      spec.reconfig = 1'b1;
      spec.dport    = port;
      spec.mask     = mask;
      return spec;
   endfunction

   // Mostly well-formed UDP frames with random content, the rest noise
   task automatic draw_frame(input bit tiny, output frame_spec_type spec);
      int unsigned hdr;
      spec = '0;
      spec.queue = $urandom_range(63);
      spec.dport = ($urandom_range(9) < 7) ? port_cfg : $urandom_range(65535);
      spec.ulen  = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(65535, 8);
      if (!tiny && $urandom_range(99) < 65) begin
         spec.proto = PROTO_UDP;
         if ($urandom_range(1)) begin
            spec.kind = ETHERTYPE_IPV4;
            spec.ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
            hdr = ETH_HDR_LEN + 4 * spec.ihl;
         end else begin
            spec.kind = ETHERTYPE_IPV6;
            hdr = ETH_HDR_LEN + IPV6_HDR_LEN;
         end
         spec.len = hdr + UDP_HDR_LEN + $urandom_range(24);
         // now and then cut into the UDP header
         if ($urandom_range(19) == 0) spec.len = hdr + $urandom_range(7);
      end else begin
         case ($urandom_range(2))
            0:       spec.kind = ETHERTYPE_IPV4;
            1:       spec.kind = ETHERTYPE_IPV6;
            default: spec.kind = $urandom_range(65535);
         endcase
         spec.ihl   = $urandom_range(15);
         spec.proto = $urandom_range(1) ? PROTO_UDP : $urandom_range(255);
         spec.len   = tiny ? $urandom_range(14, 1) : $urandom_range(80, 1);
      end
   endtask

   initial begin : stimulus
      frame_spec_type directed[$];
      frame_spec_type spec;
      logic [PORT_W-1:0] port;
      logic [MASK_W-1:0] mask;
      int phase;
      int k;
      int unsigned phase_bytes;

      req_link.valid        = 1'b0;
      req_link.frame_byte   = '0;
      req_link.end_of_frame = 1'b0;
      req_link.rx_queue     = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_STEER_PORT;
      csr_wr_data = '0;
      port_cfg  = STEER_PORT_RESET;
      mask_cfg  = '0;
      cur_pos   = 0;
      kind_seen = '0;
      hdr_end   = 0;
      l4_proto  = '0;
      udp_len   = '0;
      udp_dport = '0;
      ip_kind   = STATUS_OTHER;
      for (k = 0; k < NUM_QUEUES; k++) match_count[k] = '0;

      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: short frames, bad headers, port match, redirect
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 8, 1, 7,
                                   1, VERDICT_ABORT, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 8, 13, 63,
                                   1, VERDICT_ABORT, 0, 0));
      directed.push_back(frame_row(16'h0000, 5, PROTO_UDP, 8890, 8, 14, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(16'hFFFF, 5, PROTO_UDP, 8890, 8, 14, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 8, 33, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 4, PROTO_UDP, 8890, 8, 34, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 15, PROTO_UDP, 8890, 8, 40, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, 8'd6, 8890, 8, 42, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV6, 0, PROTO_UDP, 8890, 8, 53, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV6, 0, 8'hFF, 8890, 8, 54, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 8, 41, 0,
                                   1, VERDICT_ABORT, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV6, 0, PROTO_UDP, 8890, 8, 61, 0,
                                   1, VERDICT_ABORT, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 7, 42, 0,
                                   1, VERDICT_ABORT, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8889, 8, 42, 0,
                                   1, VERDICT_PASS, 0, 0));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 8890, 8, 42, 0,
                                   1, VERDICT_PASS, 0, 1));
      directed.push_back(frame_row(ETHERTYPE_IPV6, 0, PROTO_UDP, 8890, 16'hFFFF, 62, 63,
                                   1, VERDICT_PASS, 0, 1));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 15, PROTO_UDP, 8890, 100, 82, 0,
                                   1, VERDICT_PASS, 0, 2));
      directed.push_back(reconfig_row(16'hFFFF, '1));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 16'hFFFF, 8, 42, 63,
                                   1, VERDICT_REDIRECT, 63, 2));
      directed.push_back(frame_row(ETHERTYPE_IPV6, 0, PROTO_UDP, 16'hFFFF, 16'hFFFF, 62, 5,
                                   1, VERDICT_REDIRECT, 5, 1));
      directed.push_back(reconfig_row(16'h0000, 64'h8000_0000_0000_0001));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 16'h0000, 8, 42, 0,
                                   1, VERDICT_REDIRECT, 0, 3));
      directed.push_back(frame_row(ETHERTYPE_IPV4, 5, PROTO_UDP, 16'h0000, 8, 42, 1,
                                   0, VERDICT_ABORT, 0, 0));

      for (k = 0; k < directed.size(); k++) begin
         if (directed[k].reconfig) begin
            apply_config(directed[k].dport, directed[k].mask);
         end else begin
            build_frame(directed[k]);
            send_frame(directed[k]);
         end
      end

      // Random phases, each under its own register setting
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               port = '0;
               mask = '0;
            end
            2: begin
               port = '1;
               mask = '1;
            end
            default: begin
               port = $urandom_range(65535);
               mask = {$urandom(), $urandom()};
            end
         endcase
         apply_config(port, mask);
         sender_gappy   = (phase != 1);
         receiver_gappy = (phase != 1);
         phase_bytes  = 0;
         // fill the block: hold the receiver off while tiny frames keep coming
         if (phase == 3) begin
            sender_gappy = 1'b0;
            hold_request = 1'b1;
            for (k = 0; k < 10; k++) begin
               draw_frame(1'b1, spec);
               build_frame(spec);
               send_frame(spec);
            end
            sender_gappy = 1'b1;
         end
         while (phase_bytes < 24) begin
            draw_frame(1'b0, spec);
            build_frame(spec);
            send_frame(spec);
            phase_bytes += spec.len;
         end
      end

      drain();
      repeat (SETTLE_CYCLES * 3) @(posedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("PASS udp_port_packet_steering_top");
      end else begin
         $display("FAIL udp_port_packet_steering_top");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("FAIL udp_port_packet_steering_top");
      $finish;
   end

endmodule
